// ===== rtl/rtpsrb_pkg.sv =====
// Shared constants and types for the RTP sequence reorder buffer.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package rtpsrb_pkg;

   // Pending table size and the widths that follow from it
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Fixed field widths
   localparam int REQ_W    = 2;
   localparam int SEQ_W    = 16;
   localparam int HANDLE_W = 16;
   localparam int LOST_W   = 15;
   localparam int WIN_W    = 5;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH  = 2'd0,
      REQ_FLUSH = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // One pending table entry as stored in the RAM
   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== rtl/rtp_sequence_reorder_buffer_top.sv =====
// Top level of the RTP sequence reorder buffer: sequencer, scan unit and result register.
// Depends on rtpsrb_pkg and rtpsrb_ram.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents
// csr_      in         write_enable         window_size (5 bits), written on enable
// req_      in         valid / stall        req_type, seq_number, payload_handle
// rsp_      out        valid / stall        one released packet (or none) plus stats
//
// One transaction at a time. Every table search is one pass of a single
// compare unit over the entry RAM, which has a registered read;
// the duplicate and drain searches stop at their match. A push runs the duplicate
// search, a gap search when the window is reached, one drain pass per released
// packet and one final drain pass, plus a result state for each result.
// Late packets, clear, unknown requests and a flush of an empty table skip the search.
// Reset clears the table valid bits at once; no clearing pass is needed.
// rsp_stall holds the sequencer in its result state; req_stall is high whenever the
// sequencer is not idle.

module rtp_sequence_reorder_buffer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rtpsrb_pkg::WIN_W-1:0]    csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rtpsrb_pkg::REQ_W-1:0]    req_type,
   input  logic [rtpsrb_pkg::SEQ_W-1:0]    req_seq_number,
   input  logic [rtpsrb_pkg::HANDLE_W-1:0] req_payload_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_packet_valid,
   output logic [rtpsrb_pkg::SEQ_W-1:0]    rsp_out_seq_number,
   output logic [rtpsrb_pkg::HANDLE_W-1:0] rsp_out_payload_handle,
   output logic                            rsp_last_in_run,
   output logic [rtpsrb_pkg::LOST_W-1:0]   rsp_lost_count,
   output logic                            rsp_duplicate,
   output logic                            rsp_reordered,
   output logic                            rsp_discontinuity
);
   import rtpsrb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DUP_SCAN = 6'b000010,  // search for the pushed number and a free slot
      ST_GAP_SCAN = 6'b000100,  // search for the nearest pending packet ahead
      ST_DRN_SCAN = 6'b001000,  // search for the expected number
      ST_OUT_MID  = 6'b010000,  // result that more results follow
      ST_OUT_LAST = 6'b100000   // final result of the transaction
   } state_type;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(TABLE_DEPTH);

   // Control state
   state_type               state_ff, state_in;
   logic [WIN_W-1:0]        window_ff, window_in;
   logic                    started_ff, started_in;
   logic [SEQ_W-1:0]        expected_ff, expected_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic                    free_found_ff, free_found_in;
   logic                    gap_found_ff, gap_found_in;
   logic                    have_cand_ff, have_cand_in;
   logic [CNT_W-1:0]        rel_cnt_ff, rel_cnt_in;

   // Payload state
   logic [SEQ_W-1:0]        req_seq_ff, req_seq_in;
   logic [HANDLE_W-1:0]     req_handle_ff, req_handle_in;
   logic [SEQ_W-1:0]        dist_ff, dist_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [LOST_W-1:0]       best_ff, best_in;
   logic [SEQ_W-1:0]        target_ff, target_in;
   entry_type               cand_ff, cand_in;
   logic                    out_pkt_ff, out_pkt_in;
   entry_type               out_ent_ff, out_ent_in;
   logic                    out_last_ff, out_last_in;
   logic [LOST_W-1:0]       lost_ff, lost_in;
   logic                    dup_ff, dup_in;
   logic                    reord_ff, reord_in;
   logic                    disc_ff, disc_in;

   // Entry RAM
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   entry_type               ram_wr_data;
   entry_type               ram_rd_data;

   // Scan unit
   logic                    scanning;
   logic                    chk_live;
   logic                    chk_last;
   logic [SEQ_W-1:0]        diff;
   logic                    dup_hit;
   logic                    drn_hit;
   logic                    free_now;
   logic                    slot_found;
   logic [IDX_W-1:0]        slot_idx;
   logic                    gap_take;
   logic                    gap_found_nx;
   logic [LOST_W-1:0]       best_nx;
   logic [SEQ_W-1:0]        target_nx;
   logic                    scan_end;
   logic [SEQ_W-1:0]        win_ext;
   logic [SEQ_W-1:0]        win_eff;
   logic [SEQ_W-1:0]        push_dist;
   logic [CNT_W-1:0]        count_inc;

   rtpsrb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Effective window: zero acts as one, clamp to the table size
   assign win_ext = SEQ_W'(window_ff);
   assign win_eff = (window_ff == '0) ? SEQ_W'(1) :
                    ((win_ext > DEPTH_SEQ) ? DEPTH_SEQ : win_ext);

   assign push_dist = started_ff ? (req_seq_number - expected_ff) : '0;
   assign count_inc = count_ff + CNT_W'(1);

   // One compare step per cycle on the entry read out of the RAM
   assign scanning = (state_ff == ST_DUP_SCAN) || (state_ff == ST_GAP_SCAN) ||
                     (state_ff == ST_DRN_SCAN);
   assign chk_live = chk_vld_ff && valid_ff[chk_idx_ff];
   assign chk_last = chk_vld_ff && (chk_idx_ff == LAST_IDX);
   assign diff     = ram_rd_data.seq - expected_ff;

   assign dup_hit  = chk_live && (ram_rd_data.seq == req_seq_ff);
   assign drn_hit  = chk_live && (ram_rd_data.seq == expected_ff);

   assign free_now   = chk_vld_ff && !valid_ff[chk_idx_ff];
   assign slot_found = free_found_ff || free_now;
   assign slot_idx   = free_found_ff ? free_idx_ff : chk_idx_ff;

   assign gap_take     = chk_live && !diff[SEQ_W-1] &&
                         (!gap_found_ff || (diff[LOST_W-1:0] < best_ff));
   assign gap_found_nx = gap_found_ff || gap_take;
   assign best_nx      = gap_take ? diff[LOST_W-1:0] : best_ff;
   assign target_nx    = gap_take ? ram_rd_data.seq : target_ff;

   always_comb begin
      case (state_ff)
         ST_DUP_SCAN: scan_end = chk_last || dup_hit;
         ST_GAP_SCAN: scan_end = chk_last;
         ST_DRN_SCAN: scan_end = chk_last || drn_hit;
         default:     scan_end = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      window_in     = csr_write_enable ? csr_write_data : window_ff;
      started_in    = started_ff;
      expected_in   = expected_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      have_cand_in  = have_cand_ff;
      rel_cnt_in    = rel_cnt_ff;
      req_seq_in    = req_seq_ff;
      req_handle_in = req_handle_ff;
      dist_in       = dist_ff;
      cand_in       = cand_ff;
      out_pkt_in    = out_pkt_ff;
      out_ent_in    = out_ent_ff;
      out_last_in   = out_last_ff;
      lost_in       = lost_ff;
      dup_in        = dup_ff;
      reord_in      = reord_ff;
      disc_in       = disc_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_idx;
      ram_wr_data   = '{seq: req_seq_ff, handle: req_handle_ff};

      // Advance the scan address; restart from entry zero after every pass
      scan_cnt_in   = '0;
      chk_vld_in    = 1'b0;
      chk_idx_in    = scan_cnt_ff[IDX_W-1:0];
      if (scanning && !scan_end) begin
         chk_vld_in  = scan_cnt_ff < DEPTH_CNT;
         scan_cnt_in = (scan_cnt_ff < DEPTH_CNT) ? scan_cnt_ff + CNT_W'(1) : scan_cnt_ff;
      end

      free_found_in = (state_ff == ST_DUP_SCAN) && !scan_end && slot_found;
      free_idx_in   = slot_idx;
      gap_found_in  = (state_ff == ST_GAP_SCAN) && !scan_end && gap_found_nx;
      best_in       = best_nx;
      target_in     = target_nx;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_seq_in    = req_seq_number;
               req_handle_in = req_payload_handle;
               dist_in       = push_dist;
               have_cand_in  = 1'b0;
               rel_cnt_in    = '0;
               lost_in       = '0;
               dup_in        = 1'b0;
               reord_in      = 1'b0;
               disc_in       = 1'b0;
               out_pkt_in    = 1'b0;
               out_ent_in    = '0;
               out_last_in   = 1'b1;
               state_in      = ST_OUT_LAST;
               case (req_type)
                  REQ_PUSH: begin
                     if (!started_ff) begin
                        started_in  = 1'b1;
                        expected_in = req_seq_number;
                     end
                     // Late packets drop without a search
                     if (push_dist[SEQ_W-1]) begin
                        dup_in = 1'b1;
                     end else begin
                        state_in = ST_DUP_SCAN;
                     end
                  end
                  REQ_FLUSH: begin
                     if (count_ff != '0) begin
                        state_in = ST_GAP_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     started_in  = 1'b0;
                     expected_in = '0;
                     valid_in    = '0;
                     count_in    = '0;
                  end
                  default: begin
                     state_in = ST_OUT_LAST;
                  end
               endcase
            end
         end

         ST_DUP_SCAN: begin
            if (scan_end) begin
               if (dup_hit || !slot_found) begin
                  dup_in   = 1'b1;
                  state_in = ST_OUT_LAST;
               end else begin
                  // Store the packet, then decide between gap release and drain
                  ram_wr_en          = 1'b1;
                  valid_in[slot_idx] = 1'b1;
                  count_in           = count_inc;
                  reord_in           = dist_ff != '0;
                  if ((dist_ff >= win_eff) || (SEQ_W'(count_inc) >= win_eff)) begin
                     state_in = ST_GAP_SCAN;
                  end else begin
                     state_in = ST_DRN_SCAN;
                  end
               end
            end
         end

         ST_GAP_SCAN: begin
            if (scan_end) begin
               if (!gap_found_nx) begin
                  // Nothing pending lies ahead: drop the whole table
                  valid_in = '0;
                  count_in = '0;
                  state_in = ST_OUT_LAST;
               end else begin
                  if (best_nx != '0) begin
                     lost_in     = best_nx;
                     disc_in     = 1'b1;
                     expected_in = target_nx;
                  end
                  state_in = ST_DRN_SCAN;
               end
            end
         end

         ST_DRN_SCAN: begin
            if (scan_end) begin
               if (drn_hit && (rel_cnt_ff < DEPTH_CNT)) begin
                  // Release the entry; the previous one goes out as a non-final result
                  valid_in[chk_idx_ff] = 1'b0;
                  count_in             = count_ff - CNT_W'(1);
                  expected_in          = expected_ff + SEQ_W'(1);
                  rel_cnt_in           = rel_cnt_ff + CNT_W'(1);
                  cand_in              = ram_rd_data;
                  have_cand_in         = 1'b1;
                  if (have_cand_ff) begin
                     out_pkt_in  = 1'b1;
                     out_ent_in  = cand_ff;
                     out_last_in = 1'b0;
                     state_in    = ST_OUT_MID;
                  end
               end else begin
                  out_pkt_in  = have_cand_ff;
                  out_ent_in  = have_cand_ff ? cand_ff : '0;
                  out_last_in = 1'b1;
                  state_in    = ST_OUT_LAST;
               end
            end
         end

         ST_OUT_MID: begin
            if (!rsp_stall) begin
               state_in = ST_DRN_SCAN;
            end
         end

         ST_OUT_LAST: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= WINDOW_RESET;
         started_ff    <= 1'b0;
         expected_ff   <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         scan_cnt_ff   <= '0;
         chk_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         gap_found_ff  <= 1'b0;
         have_cand_ff  <= 1'b0;
         rel_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         started_ff    <= started_in;
         expected_ff   <= expected_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         scan_cnt_ff   <= scan_cnt_in;
         chk_vld_ff    <= chk_vld_in;
         free_found_ff <= free_found_in;
         gap_found_ff  <= gap_found_in;
         have_cand_ff  <= have_cand_in;
         rel_cnt_ff    <= rel_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      req_seq_ff    <= req_seq_in;
      req_handle_ff <= req_handle_in;
      dist_ff       <= dist_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      target_ff     <= target_in;
      cand_ff       <= cand_in;
      out_pkt_ff    <= out_pkt_in;
      out_ent_ff    <= out_ent_in;
      out_last_ff   <= out_last_in;
      lost_ff       <= lost_in;
      dup_ff        <= dup_in;
      reord_ff      <= reord_in;
      disc_ff       <= disc_in;
   end

   assign req_stall              = state_ff != ST_IDLE;
   assign rsp_valid              = (state_ff == ST_OUT_MID) || (state_ff == ST_OUT_LAST);
   assign rsp_packet_valid       = out_pkt_ff;
   assign rsp_out_seq_number     = out_ent_ff.seq;
   assign rsp_out_payload_handle = out_ent_ff.handle;
   assign rsp_last_in_run        = out_last_ff;
   assign rsp_lost_count         = lost_ff;
   assign rsp_duplicate          = dup_ff;
   assign rsp_reordered          = reord_ff;
   assign rsp_discontinuity      = disc_ff;

endmodule

// ===== rtl/rtpsrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rtpsrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/rtpsrb_checker.sv =====
// Port-level assertions for the RTP sequence reorder buffer, bound to the top level.
// Depends on rtpsrb_pkg and rtp_sequence_reorder_buffer_top.
`timescale 1ns / 1ps

module rtpsrb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_write_enable,
   input logic [rtpsrb_pkg::WIN_W-1:0]    csr_write_data,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [rtpsrb_pkg::REQ_W-1:0]    req_type,
   input logic [rtpsrb_pkg::SEQ_W-1:0]    req_seq_number,
   input logic [rtpsrb_pkg::HANDLE_W-1:0] req_payload_handle,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_packet_valid,
   input logic [rtpsrb_pkg::SEQ_W-1:0]    rsp_out_seq_number,
   input logic [rtpsrb_pkg::HANDLE_W-1:0] rsp_out_payload_handle,
   input logic                            rsp_last_in_run,
   input logic [rtpsrb_pkg::LOST_W-1:0]   rsp_lost_count,
   input logic                            rsp_duplicate,
   input logic                            rsp_reordered,
   input logic                            rsp_discontinuity
);
   import rtpsrb_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_seq_number) &&
      $stable(rsp_out_payload_handle) && $stable(rsp_last_in_run) &&
      $stable(rsp_packet_valid) && $stable(rsp_lost_count))
      else $error("stalled result changed");

   // No new transaction while a result is pending
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // One transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // A result without a packet ends its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_packet_valid |-> rsp_last_in_run)
      else $error("empty result not last");

endmodule

bind rtp_sequence_reorder_buffer_top rtpsrb_checker u_rtpsrb_checker (.*);

// ===== dv/rtp_sequence_reorder_buffer_top_tb.sv =====
// Self-checking testbench for rtp_sequence_reorder_buffer_top: directed and random requests
// against a cycle-free predictor of the reorder table. Depends on rtpsrb_pkg and the RTL.
`timescale 1ns / 1ps

module rtp_sequence_reorder_buffer_top_tb;
   import rtpsrb_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;   // undefined request code
   localparam int HALF_RANGE  = 'h8000;
   localparam int CYCLE_LIMIT = 500000;
   localparam int END_DRAIN   = 400;                 // longer than the slowest request

   typedef struct {
      logic                packet_valid;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic                last_in_run;
      logic [LOST_W-1:0]   lost;
      logic                duplicate;
      logic                reordered;
      logic                discontinuity;
   } release_result_type;

   // DUT ports
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [WIN_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type = '0;
   logic [SEQ_W-1:0]    req_seq_number = '0;
   logic [HANDLE_W-1:0] req_payload_handle = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_packet_valid;
   logic [SEQ_W-1:0]    rsp_out_seq_number;
   logic [HANDLE_W-1:0] rsp_out_payload_handle;
   logic                rsp_last_in_run;
   logic [LOST_W-1:0]   rsp_lost_count;
   logic                rsp_duplicate;
   logic                rsp_reordered;
   logic                rsp_discontinuity;

   // Predicted reorder state
   bit                  seen_first;
   logic [SEQ_W-1:0]    next_seq;
   bit                  slot_busy   [TABLE_DEPTH];
   logic [SEQ_W-1:0]    slot_seq    [TABLE_DEPTH];
   logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH];
   logic [WIN_W-1:0]    window_reg = WINDOW_RESET;

   // Per-request scratch of the predictor
   logic [SEQ_W-1:0]    run_seq    [$];
   logic [HANDLE_W-1:0] run_handle [$];
   int unsigned         skipped;
   bit                  jumped;

   release_result_type  expected_releases [$];
   release_result_type  want_result;

   bit                  idling_on = 1'b1;
   int                  stall_left = 0;
   int                  error_count = 0;
   int                  requests_sent = 0;
   int                  results_checked = 0;
   int                  packets_seen = 0;
   int                  duplicates_seen = 0;
   int                  gaps_seen = 0;
   int                  cycle_count = 0;

   rtp_sequence_reorder_buffer_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_type               (req_type),
      .req_seq_number         (req_seq_number),
      .req_payload_handle     (req_payload_handle),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_packet_valid       (rsp_packet_valid),
      .rsp_out_seq_number     (rsp_out_seq_number),
      .rsp_out_payload_handle (rsp_out_payload_handle),
      .rsp_last_in_run        (rsp_last_in_run),
      .rsp_lost_count         (rsp_lost_count),
      .rsp_duplicate          (rsp_duplicate),
      .rsp_reordered          (rsp_reordered),
      .rsp_discontinuity      (rsp_discontinuity)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_releases.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int find_entry(logic [SEQ_W-1:0] seq);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot_busy[i] && slot_seq[i] == seq) return i;
      return -1;
   endfunction

   function automatic int busy_count();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot_busy[i]) n++;
      return n;
   endfunction

   function automatic int effective_window();
      if (window_reg == 0) return 1;
      if (window_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(window_reg);
   endfunction

   // Release consecutive packets starting at the expected number
   function automatic void release_in_order();
      int i;
      forever begin
         i = find_entry(next_seq);
         if (i < 0 || run_seq.size() >= TABLE_DEPTH) break;
         run_seq.insert(run_seq.size(), slot_seq[i]);
         run_handle.insert(run_handle.size(), slot_handle[i]);
         slot_busy[i] = 1'b0;
         next_seq++;
      end
   endfunction

   // Jump to the nearest pending packet ahead; empty the table if none lies ahead
   function automatic void skip_gap();
      int               best;
      logic [SEQ_W-1:0] target;
      logic [SEQ_W-1:0] ahead;
      best   = 'h10000;
      target = '0;
      if (busy_count() == 0) return;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_busy[i]) begin
            ahead = slot_seq[i] - next_seq;
            if (ahead < HALF_RANGE && ahead < best) begin
               best   = int'(ahead);
               target = slot_seq[i];
            end
         end
      end
      if (best == 'h10000) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_busy[i] = 1'b0;
         return;
      end
      if (best > 0) begin
         skipped += best;
         jumped   = 1'b1;
         next_seq = target;
      end
      release_in_order();
   endfunction

   // Advance the predicted state by one accepted request and queue its results
   function automatic void compute_releases(logic [REQ_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                            logic [HANDLE_W-1:0] handle);
      logic [SEQ_W-1:0]   ahead;
      int                 free_slot;
      int                 win;
      int                 n;
      bit                 dup_flag;
      bit                 early_flag;
      release_result_type res;
      dup_flag   = 1'b0;
      early_flag = 1'b0;
      run_seq.delete();
      run_handle.delete();
      skipped = 0;
      jumped  = 1'b0;
      if (kind == REQ_PUSH) begin
         if (!seen_first) begin
            seen_first = 1'b1;
            next_seq   = seq;
         end
         ahead = seq - next_seq;
         if (ahead >= HALF_RANGE || find_entry(seq) >= 0) begin
            dup_flag = 1'b1;
         end else begin
            free_slot = -1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
               if (!slot_busy[i]) free_slot = i;
            if (free_slot < 0) begin
               dup_flag = 1'b1;
            end else begin
               win        = effective_window();
               early_flag = (ahead > 0);
               slot_busy[free_slot]   = 1'b1;
               slot_seq[free_slot]    = seq;
               slot_handle[free_slot] = handle;
               if (ahead >= win || busy_count() >= win) skip_gap();
               else release_in_order();
            end
         end
      end else if (kind == REQ_FLUSH) begin
         skip_gap();
      end else if (kind == REQ_CLEAR) begin
         seen_first = 1'b0;
         next_seq   = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) slot_busy[i] = 1'b0;
      end
      duplicates_seen += dup_flag;
      gaps_seen       += jumped;
      n = (run_seq.size() > 0) ? run_seq.size() : 1;
      for (int k = 0; k < n; k++) begin
         res.packet_valid  = (k < run_seq.size());
         res.seq           = res.packet_valid ? run_seq[k] : '0;
         res.handle        = res.packet_valid ? run_handle[k] : '0;
         res.last_in_run   = (k == n - 1);
         res.lost          = LOST_W'(skipped);
         res.duplicate     = dup_flag;
         res.reordered     = early_flag;
         res.discontinuity = jumped;
         expected_releases.insert(expected_releases.size(), res);
      end
   endfunction

   // ---------------------------------------------------------------- result checker

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endfunction

   // Check each accepted result; while idling is on, hold off the next one for a random number of cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            packets_seen += rsp_packet_valid;
            if (expected_releases.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, seq 0x%0h handle 0x%0h", $time,
                        rsp_out_seq_number, rsp_out_payload_handle);
            end else begin
               want_result = expected_releases.pop_front();
               compare_field("packet_valid", want_result.packet_valid, rsp_packet_valid);
               compare_field("out_seq_number", want_result.seq, rsp_out_seq_number);
               compare_field("out_payload_handle", want_result.handle, rsp_out_payload_handle);
               compare_field("last_in_run", want_result.last_in_run, rsp_last_in_run);
               compare_field("lost_count", want_result.lost, rsp_lost_count);
               compare_field("duplicate", want_result.duplicate, rsp_duplicate);
               compare_field("reordered", want_result.reordered, rsp_reordered);
               compare_field("discontinuity", want_result.discontinuity, rsp_discontinuity);
            end
            stall_left = idling_on ? $urandom_range(0, 5) : 0;
            rsp_stall <= (stall_left != 0);
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Send one request; valid stays high on return so a back-to-back request keeps it up
   task automatic send_request(logic [REQ_W-1:0] kind, logic [SEQ_W-1:0] seq,
                               logic [HANDLE_W-1:0] handle);
      int gap;
      gap = idling_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_seq_number     <= seq;
      req_payload_handle <= handle;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      compute_releases(kind, seq, handle);
   endtask

   task automatic push(logic [SEQ_W-1:0] seq, logic [HANDLE_W-1:0] handle);
      send_request(REQ_PUSH, seq, handle);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_releases.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      window_reg        = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_first_packet_and_wrap();
      push(16'hFFFE, 16'h0000);      // first packet sets the expected number
      push(16'h0000, 16'hFFFF);      // ahead across the wrap, held
      push(16'hFFFF, 16'h1234);      // fills the hole, two released
      push(16'hFFFF, 16'h5555);      // late
   endtask

   task automatic test_reorder_and_duplicates();
      push(16'h0003, 16'h00FF);
      push(16'h0003, 16'hFF00);      // already pending
      push(16'h0002, 16'h0F0F);
      push(16'h0001, 16'hF0F0);      // releases the run 1..3
   endtask

   task automatic test_flush_clear_unknown();
      push(16'h0006, 16'hAAAA);
      push(16'h0005, 16'h5555);
      send_request(REQ_FLUSH, 16'h0000, 16'h0000);     // skip 4, release 5 and 6
      send_request(REQ_FLUSH, 16'hFFFF, 16'hFFFF);     // empty table, nothing released
      send_request(REQ_UNKNOWN, 16'hFFFF, 16'hFFFF);
      send_request(REQ_CLEAR, 16'h1234, 16'h4321);
      push(16'h8000, 16'hABCD);      // first packet again after clear
   endtask

   task automatic test_window_limits();
      write_window(5'd0);            // behaves as one
      push(16'h8005, 16'h0001);
      push(16'h8006, 16'h0002);
      write_window(5'd31);           // clipped to the table depth
      push(16'h8017, 16'h0003);
      push(16'h8027, 16'h0004);
      write_window(5'd3);            // pending count reaches the window
      push(16'h8019, 16'h0005);
      push(16'h801A, 16'h0006);
   endtask

   // Mostly near-in-order pushes around the expected number, with late, far,
   // repeated and control requests mixed in
   task automatic test_random_traffic(logic [WIN_W-1:0] window, bit idle, int count);
      int                  pick;
      int                  start;
      logic [REQ_W-1:0]    kind;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      write_window(window);
      idling_on = idle;
      for (int n = 0; n < count; n++) begin
         kind   = REQ_PUSH;
         seq    = SEQ_W'($urandom);
         handle = HANDLE_W'($urandom);
         pick   = $urandom_range(0, 99);
         if (pick < 55) begin
            seq = SEQ_W'(next_seq + $urandom_range(0, 3));
         end else if (pick < 68) begin
            seq = SEQ_W'(next_seq + $urandom_range(4, 20));
         end else if (pick < 76) begin
            seq = SEQ_W'(next_seq - $urandom_range(1, HALF_RANGE));
         end else if (pick < 79) begin
            seq = SEQ_W'(next_seq + $urandom_range(HALF_RANGE - 16, HALF_RANGE - 1));
         end else if (pick < 85) begin
            start = $urandom_range(0, TABLE_DEPTH - 1);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_busy[(start + i) % TABLE_DEPTH]) begin
                  seq = slot_seq[(start + i) % TABLE_DEPTH];
                  break;
               end
            end
         end else if (pick < 91) begin
            kind = REQ_FLUSH;
         end else if (pick < 94) begin
            kind = REQ_CLEAR;
         end else if (pick < 96) begin
            kind = REQ_UNKNOWN;
         end
         send_request(kind, seq, handle);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_first_packet_and_wrap();
      test_reorder_and_duplicates();
      test_flush_clear_unknown();
      test_window_limits();

      test_random_traffic(5'd16, 1'b1, 30);
      test_random_traffic(5'd1, 1'b0, 30);
      test_random_traffic(5'd31, 1'b1, 30);
      test_random_traffic(5'd0, 1'b0, 30);
      test_random_traffic(WIN_W'($urandom_range(2, 15)), 1'b1, 30);

      // Let any stray result show up before the verdict
      settle();
      repeat (END_DRAIN) @(posedge clock);

      $display("Covered %0d requests over windows 0, 1, 3, 16, 31 and a random one", requests_sent);
      $display("Checked %0d results: %0d packets released, %0d duplicates, %0d gap jumps",
               results_checked, packets_seen, duplicates_seen, gaps_seen);
      if (error_count == 0 && expected_releases.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rtpsrb_pkg.sv
rtl/rtpsrb_ram.sv
rtl/rtp_sequence_reorder_buffer_top.sv
rtl/rtpsrb_checker.sv
dv/rtp_sequence_reorder_buffer_top_tb.sv
